/* hw/rtl/mmc_pkg.sv */
// Shared types and constants for the matrix mean centering unit.
// No dependencies; mmc_csr and the top-level unit import this package.
`default_nettype none

package mmc_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] centered_value;
      logic               element_last;
      logic               fetch_error;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INDEX,
      S_LOAD_UPD,
      S_FETCH_RD,
      S_MEAN,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/mmc_div.sv */
// Iterative unsigned restoring divider, four quotient bits per cycle.
// Depends on nothing but its parameters; shared for index split and mean.
`default_nettype none

module mmc_div #(
   parameter int NUM_W = 39,
   parameter int DEN_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient,
   output logic [DEN_W-1:0]      remainder
);

   localparam int STEPS = 4;
   localparam int NP    = ((NUM_W + STEPS - 1) / STEPS) * STEPS;
   localparam int CYC   = NP / STEPS;
   localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;

   logic [NP-1:0]    q_ff, q_in;
   logic [DEN_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff;
   logic             done_ff;

   always_comb begin
      logic [DEN_W:0]   t;
      logic [DEN_W-1:0] r;
      logic [NP-1:0]    q;
      r = r_ff;
      q = q_ff;
      for (int i = 0; i < STEPS; i++) begin
         t = {r, q[NP-1]};
         q = {q[NP-2:0], 1'b0};
         if (t >= {1'b0, d_ff}) begin
            t    = t - {1'b0, d_ff};
            q[0] = 1'b1;
         end
         r = t[DEN_W-1:0];
      end
      q_in = q;
      r_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CYC - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= NP'(dividend);
         r_ff <= '0;
         d_ff <= divisor;
      end else if (run_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff[NUM_W-1:0];
   assign remainder = r_ff;

endmodule

`default_nettype wire

/* hw/rtl/mmc_csr.sv */
// Configuration registers: axis select and matrix dimensions, clamped.
// Depends on mmc_pkg for register indexes and port widths.
`default_nettype none

module mmc_csr
   import mmc_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64,
   parameter int DIM_W    = 7,
   parameter int TOT_W    = 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       axis,
   output logic [DIM_W-1:0]           num_rows,
   output logic [DIM_W-1:0]           num_cols,
   output logic [TOT_W-1:0]           total
);

   logic                  axis_ff;
   logic [CSR_DATA_W-1:0] rows_ff;
   logic [CSR_DATA_W-1:0] cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= 1'b0;
         rows_ff <= CSR_DATA_W'(64);
         cols_ff <= CSR_DATA_W'(64);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_AXIS: axis_ff <= csr_wdata[0];
            CSR_ROWS: rows_ff <= csr_wdata;
            CSR_COLS: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // saturate dimensions into 1..MAX
   always_comb begin
      if (rows_ff == '0)
         num_rows = DIM_W'(1);
      else if (32'(rows_ff) > MAX_ROWS)
         num_rows = DIM_W'(MAX_ROWS);
      else
         num_rows = DIM_W'(rows_ff);
      if (cols_ff == '0)
         num_cols = DIM_W'(1);
      else if (32'(cols_ff) > MAX_COLS)
         num_cols = DIM_W'(MAX_COLS);
      else
         num_cols = DIM_W'(cols_ff);
   end

   assign total     = TOT_W'(TOT_W'(num_rows) * TOT_W'(num_cols));
   assign axis      = axis_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

/* hw/rtl/matrix_mean_centering_unit.sv */
// Matrix mean centering unit: load a matrix, fetch it back mean-centered.
// Depends on mmc_pkg, mmc_csr (configuration) and mmc_div (shared divider).
//
// Channels: req carries {operation, sample_value}; a load beat stores one
// element in row-major order and adds it to its row or column sum, a fetch
// beat returns one rsp beat {centered_value, element_last, fetch_error}.
// csr writes axis (index 0), rows (1) and cols (2); write only when idle.
// Sequence: each beat first splits its linear index into row and column on
// the shared four-bit-per-cycle divider. A load then writes the element,
// reads its sum and writes the updated sum back in S_LOAD_UPD. A fetch reads
// element and sum, runs the divider again for the mean and subtracts. A
// fetch before a complete load answers with fetch_error set.
// One beat is in flight at a time. The rsp register holds a result while
// the receiver stalls and the next req beat is still taken; only a second
// result waits for the register to drain.
// Reset clears indices, the loaded flag and the sum valid bits; there is
// no clearing pass, the element memory is simply written before use.
`default_nettype none

module matrix_mean_centering_unit
   import mmc_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_D = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int DIM_W = $clog2(SUM_D + 1);
   localparam int TOT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ADR_W = IDX_W;
   localparam int SA_W  = (SUM_D > 1) ? $clog2(SUM_D) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int SUM_W = 33 + $clog2(SUM_D + 1);
   localparam int MEAN_W = SUM_W + 1;
   localparam int DIF_W  = SUM_W + 2;
   localparam logic signed [DIF_W-1:0] SAT_HI = {{(DIF_W-32){1'b0}}, 32'h7FFF_FFFF};
   localparam logic signed [DIF_W-1:0] SAT_LO = {{(DIF_W-32){1'b1}}, 32'h8000_0000};

   // configuration
   logic             axis;
   logic [DIM_W-1:0] num_rows;
   logic [DIM_W-1:0] num_cols;
   logic [TOT_W-1:0] total;

   mmc_csr #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS),
      .DIM_W   (DIM_W),
      .TOT_W   (TOT_W)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .axis     (axis),
      .num_rows (num_rows),
      .num_cols (num_cols),
      .total    (total)
   );

   // control state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] load_index_ff, load_index_in;
   logic [IDX_W-1:0] fetch_index_ff, fetch_index_in;
   logic             loaded_ff, loaded_in;
   logic [SUM_D-1:0] sum_vld_ff, sum_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // beat context
   logic               op_ff;
   logic signed [31:0] sample_ff;
   logic               last_ff, last_in;
   logic               err_ff, err_in;
   logic [SA_W-1:0]    sa_ff;
   logic               neg_ff;
   logic signed [MEAN_W-1:0] mean_ff;
   rsp_type            rsp_data_ff, rsp_data_in;

   // memories
   logic signed [31:0]      mat_mem [DEPTH];
   logic signed [SUM_W-1:0] sum_mem [SUM_D];
   logic signed [31:0]      mat_q;
   logic signed [SUM_W-1:0] sum_q;

   // divider
   logic             div_start;
   logic [SUM_W-1:0] div_num;
   logic [DIM_W-1:0] div_den;
   logic             div_done;
   logic [SUM_W-1:0] div_quo;
   logic [DIM_W-1:0] div_rem;

   mmc_div #(
      .NUM_W(SUM_W),
      .DEN_W(DIM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // index bookkeeping
   logic [IDX_W-1:0] li_eff, fi_eff;
   logic             li_last, fi_last;

   assign li_eff  = (TOT_W'(load_index_ff) >= total) ? '0 : load_index_ff;
   assign fi_eff  = (TOT_W'(fetch_index_ff) >= total) ? '0 : fetch_index_ff;
   assign li_last = (TOT_W'(li_eff) == total - TOT_W'(1));
   assign fi_last = (TOT_W'(fi_eff) == total - TOT_W'(1));

   // addresses from divider result (row = quotient, column = remainder)
   logic [ROW_W-1:0] row_idx;
   logic [COL_W-1:0] col_idx;
   logic [ADR_W-1:0] mat_addr;
   logic [SA_W-1:0]  sum_addr;

   assign row_idx  = div_quo[ROW_W-1:0];
   assign col_idx  = div_rem[COL_W-1:0];
   assign mat_addr = ADR_W'(ADR_W'(row_idx) * ADR_W'(MAX_COLS)) + ADR_W'(col_idx);
   assign sum_addr = axis ? SA_W'(col_idx) : SA_W'(row_idx);

   // sum path
   logic signed [SUM_W-1:0] sum_base;
   logic signed [SUM_W-1:0] sum_new;
   logic [SUM_W-1:0]        sum_mag;
   logic                    sum_neg;

   assign sum_base = sum_vld_ff[sa_ff] ? sum_q : '0;
   assign sum_new  = sum_base + {{(SUM_W-32){sample_ff[31]}}, sample_ff};
   assign sum_neg  = sum_base[SUM_W-1];
   assign sum_mag  = sum_neg ? SUM_W'(-sum_base) : SUM_W'(sum_base);

   // difference and saturation
   logic signed [DIF_W-1:0] diff;
   logic signed [31:0]      diff_sat;

   assign diff = {{(DIF_W-32){mat_q[31]}}, mat_q} - {mean_ff[MEAN_W-1], mean_ff};

   always_comb begin
      if (diff > SAT_HI)
         diff_sat = SAT_HI[31:0];
      else if (diff < SAT_LO)
         diff_sat = SAT_LO[31:0];
      else
         diff_sat = diff[31:0];
   end

   logic req_acc;
   logic mat_wr, mat_rd, sum_rd, sum_wr;

   assign req_acc = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      load_index_in  = load_index_ff;
      fetch_index_in = fetch_index_ff;
      loaded_in      = loaded_ff;
      sum_vld_in     = sum_vld_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      last_in        = last_ff;
      err_in         = err_ff;
      req_ready      = 1'b0;
      div_start      = 1'b0;
      div_num        = '0;
      div_den        = num_cols;
      mat_wr         = 1'b0;
      mat_rd         = 1'b0;
      sum_rd         = 1'b0;
      sum_wr         = 1'b0;

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.operation == OP_LOAD) begin
                  // load start clears sums, loaded flag and fetch position
                  if (li_eff == '0) begin
                     sum_vld_in     = '0;
                     loaded_in      = 1'b0;
                     fetch_index_in = '0;
                  end
                  if (li_last) begin
                     loaded_in     = 1'b1;
                     load_index_in = '0;
                  end else begin
                     load_index_in = li_eff + IDX_W'(1);
                  end
                  div_start = 1'b1;
                  div_num   = SUM_W'(li_eff);
                  state_in  = S_INDEX;
               end else if (!loaded_ff) begin
                  err_in   = 1'b1;
                  state_in = S_OUT;
               end else begin
                  err_in         = 1'b0;
                  last_in        = fi_last;
                  fetch_index_in = fi_last ? '0 : fi_eff + IDX_W'(1);
                  div_start      = 1'b1;
                  div_num        = SUM_W'(fi_eff);
                  state_in       = S_INDEX;
               end
            end
         end
         S_INDEX: begin
            if (div_done) begin
               sum_rd = 1'b1;
               if (op_ff == OP_LOAD) begin
                  mat_wr   = 1'b1;
                  state_in = S_LOAD_UPD;
               end else begin
                  mat_rd   = 1'b1;
                  state_in = S_FETCH_RD;
               end
            end
         end
         S_LOAD_UPD: begin
            sum_wr            = 1'b1;
            sum_vld_in[sa_ff] = 1'b1;
            state_in          = S_IDLE;
         end
         S_FETCH_RD: begin
            div_start = 1'b1;
            div_num   = sum_mag;
            div_den   = axis ? num_rows : num_cols;
            state_in  = S_MEAN;
         end
         S_MEAN: begin
            if (div_done)
               state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the rsp register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_data_in.centered_value = '0;
                  rsp_data_in.element_last   = 1'b0;
                  rsp_data_in.fetch_error    = 1'b1;
               end else begin
                  rsp_data_in.centered_value = diff_sat;
                  rsp_data_in.element_last   = last_ff;
                  rsp_data_in.fetch_error    = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         load_index_ff  <= '0;
         fetch_index_ff <= '0;
         loaded_ff      <= 1'b0;
         sum_vld_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         load_index_ff  <= load_index_in;
         fetch_index_ff <= fetch_index_in;
         loaded_ff      <= loaded_in;
         sum_vld_ff     <= sum_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
      if (req_acc) begin
         op_ff     <= req_data.operation;
         sample_ff <= req_data.sample_value;
      end
      if (sum_rd)
         sa_ff <= sum_addr;
      if (state_ff == S_FETCH_RD)
         neg_ff <= sum_neg;
      if (state_ff == S_MEAN && div_done)
         mean_ff <= neg_ff ? -MEAN_W'(div_quo) : MEAN_W'(div_quo);
   end

   // element memory
   always_ff @(posedge clock) begin
      if (mat_wr)
         mat_mem[mat_addr] <= sample_ff;
   end

   always_ff @(posedge clock) begin
      if (mat_rd)
         mat_q <= mat_mem[mat_addr];
   end

   // sum memory
   always_ff @(posedge clock) begin
      if (sum_wr)
         sum_mem[sa_ff] <= sum_new;
   end

   always_ff @(posedge clock) begin
      if (sum_rd)
         sum_q <= sum_mem[sum_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
